@@ rtl/core/sdau_pkg.sv @@
// ----------------------------------------------------------------------------
// sdau_pkg
// shared constants for the signed integer to decimal ascii unit
// ----------------------------------------------------------------------------
package sdau_pkg;

  localparam int CHAR_BITS = 6;
  localparam int BCD_BITS = 4;
  // magnitude bits folded into the bcd register per conversion cycle
  localparam int BITS_PER_STEP = 4;

  localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_BITS-1:0] CHAR_ZERO = 6'd48;
  localparam logic [CHAR_BITS-1:0] CHAR_NINE = 6'd57;

  localparam logic [BCD_BITS-1:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [BCD_BITS-1:0] BCD_ADJ = 4'd3;

  // decimal digits needed for an unsigned magnitude of the given width
  function automatic int num_digits(input int bits);
    return ((bits * 1233) >> 12) + 1;
  endfunction

endpackage

@@ rtl/core/sdau_queue.sv @@
// ----------------------------------------------------------------------------
// sdau_queue
// two-entry queue between the front and the converter
// ----------------------------------------------------------------------------
module sdau_queue #(
  parameter int WIDTH = 33
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             q_full,
  input  logic             rd_en,
  output logic             q_valid,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;

  assign q_full  = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_en) begin
        wptr <= ~wptr;
      end
      if (rd_en) begin
        rptr <= ~rptr;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/core/sdau_front.sv @@
// ----------------------------------------------------------------------------
// sdau_front
// input register: splits the value into sign and unsigned magnitude
// ----------------------------------------------------------------------------
module sdau_front
  import sdau_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic signed [VALUE_BITS-1:0] value,
  output logic                         wr_en,
  output logic [VALUE_BITS:0]          wr_data,
  input  logic                         q_full
);

  logic                  held;
  logic                  neg;
  logic [VALUE_BITS-1:0] mag;
  logic [VALUE_BITS-1:0] v_u;
  logic                  accept;

  assign v_u    = value;
  assign wr_en  = held && !q_full;
  assign full   = held && q_full;
  assign accept = push && !full;
  assign wr_data = {neg, mag};

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (wr_en) begin
      held <= 1'b0;
    end
  end

  // most negative value: ~v + 1 wraps to itself, read as unsigned it is right
  always_ff @(posedge clk) begin
    if (accept) begin
      neg <= v_u[VALUE_BITS-1];
      mag <= v_u[VALUE_BITS-1] ? (~v_u + 1'b1) : v_u;
    end
  end

endmodule

@@ rtl/core/sdau_conv.sv @@
// ----------------------------------------------------------------------------
// sdau_conv
// binary to bcd converter, shift-and-add-3 over several bits per cycle
// ----------------------------------------------------------------------------
module sdau_conv
  import sdau_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      q_valid,
  input  logic [VALUE_BITS:0]                       rd_data,
  output logic                                      rd_en,
  output logic                                      res_valid,
  output logic                                      res_neg,
  output logic [num_digits(VALUE_BITS)*BCD_BITS-1:0] res_bcd,
  input  logic                                      res_take
);

  localparam int NumDigits = num_digits(VALUE_BITS);
  localparam int Steps     = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int MagBits   = Steps * BITS_PER_STEP;
  localparam int CntBits   = (Steps > 1) ? $clog2(Steps) : 1;
  localparam int BcdW      = NumDigits * BCD_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  state_t             state;
  logic [CntBits-1:0] cnt;
  logic [MagBits-1:0] mag;
  logic [BcdW-1:0]    bcd;
  logic               neg;
  logic [MagBits-1:0] mag_next;
  logic [BcdW-1:0]    bcd_next;
  logic               load;

  assign load      = q_valid && ((state == ST_IDLE) || ((state == ST_DONE) && res_take));
  assign rd_en     = load;
  assign res_valid = (state == ST_DONE);
  assign res_neg   = neg;
  assign res_bcd   = bcd;

  // one cycle of double dabble, BITS_PER_STEP rounds: adjust digits, shift
  always_comb begin
    logic [BcdW-1:0]    b;
    logic [MagBits-1:0] m;
    b = bcd;
    m = mag;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      for (int d = 0; d < NumDigits; d++) begin
        if (b[d*BCD_BITS +: BCD_BITS] >= BCD_ADJ_MIN) begin
          b[d*BCD_BITS +: BCD_BITS] = b[d*BCD_BITS +: BCD_BITS] + BCD_ADJ;
        end
      end
      b = {b[BcdW-2:0], m[MagBits-1]};
      m = {m[MagBits-2:0], 1'b0};
    end
    bcd_next = b;
    mag_next = m;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (load) begin
            state <= ST_RUN;
            cnt   <= CntBits'(Steps - 1);
          end
        end
        ST_RUN: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load) begin
            state <= ST_RUN;
            cnt   <= CntBits'(Steps - 1);
          end else if (res_take) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bcd <= '0;
      mag <= MagBits'(rd_data[VALUE_BITS-1:0]);
      neg <= rd_data[VALUE_BITS];
    end else if (state == ST_RUN) begin
      bcd <= bcd_next;
      mag <= mag_next;
    end
  end

endmodule

@@ rtl/core/sdau_emit.sv @@
// ----------------------------------------------------------------------------
// sdau_emit
// character sequencer with output register
// ----------------------------------------------------------------------------
module sdau_emit
  import sdau_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      res_valid,
  input  logic                                      res_neg,
  input  logic [num_digits(VALUE_BITS)*BCD_BITS-1:0] res_bcd,
  output logic                                      res_take,
  output logic [CHAR_BITS-1:0]                      char_code,
  output logic                                      last_char,
  output logic                                      empty,
  input  logic                                      pop
);

  localparam int NumDigits = num_digits(VALUE_BITS);
  localparam int IdxBits   = $clog2(NumDigits);
  localparam int BcdW      = NumDigits * BCD_BITS;

  logic [BcdW-1:0]    buf_bcd;
  logic               sign_pend;
  logic [IdxBits-1:0] idx;
  logic               busy;
  logic               out_vld;
  logic               adv;
  logic               finish;
  logic [IdxBits-1:0] top_idx;
  logic [BCD_BITS-1:0] cur_digit;

  assign empty     = !out_vld;
  assign adv       = busy && (!out_vld || pop);
  assign finish    = adv && !sign_pend && (idx == '0);
  assign res_take  = res_valid && (!busy || finish);
  assign cur_digit = buf_bcd[idx*BCD_BITS +: BCD_BITS];

  // highest nonzero digit, zero when the whole number is zero
  always_comb begin
    top_idx = '0;
    for (int d = 0; d < NumDigits; d++) begin
      if (res_bcd[d*BCD_BITS +: BCD_BITS] != '0) begin
        top_idx = IdxBits'(d);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      if (res_take) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
      if (adv) begin
        out_vld <= 1'b1;
      end else if (pop) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      buf_bcd   <= res_bcd;
      sign_pend <= res_neg;
      idx       <= top_idx;
    end else if (adv) begin
      if (sign_pend) begin
        sign_pend <= 1'b0;
      end else begin
        idx <= idx - 1'b1;
      end
    end
    if (adv) begin
      if (sign_pend) begin
        char_code <= CHAR_MINUS;
        last_char <= 1'b0;
      end else begin
        char_code <= CHAR_ZERO + CHAR_BITS'(cur_digit);
        last_char <= (idx == '0);
      end
    end
  end

endmodule

@@ rtl/core/signed_int_to_decimal_ascii_unit.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// converts signed integers to decimal ascii, at most one character a beat
// ----------------------------------------------------------------------------
// usage
//   input queue side: value is taken on a beat where push is high and full is
//   low. output queue side: while empty is low, char_code/last_char show the
//   oldest character; pop takes it. a negative number starts with '-', leading
//   zeros are dropped, zero gives a lone '0', last_char marks the final digit
// path
//   a value passes the input register and the queue on its way to the
//   converter, which builds its bcd digits and hands them to the character
//   sequencer; its output register then shows the first character
// overlap
//   converter and character sequencer overlap: the converter works on the
//   next number while the sequencer still sends out the characters of the
//   one before
// reset
//   rst (synchronous) empties the input register, the queue, the converter
//   and the output register; no clearing pass is needed
// stall
//   with pop low the current character holds; the sequencer, converter,
//   queue and input register fill in turn, then full rises
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit
  import sdau_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic signed [VALUE_BITS-1:0] value,
  output logic [CHAR_BITS-1:0]         char_code,
  output logic                         last_char,
  output logic                         empty,
  input  logic                         pop
);

  localparam int NumDigits = num_digits(VALUE_BITS);

  // front to queue
  logic                  f_wr_en;
  logic [VALUE_BITS:0]   f_wr_data;
  logic                  q_full;
  // queue to converter
  logic                  q_valid;
  logic                  q_rd_en;
  logic [VALUE_BITS:0]   q_rd_data;
  // converter to sequencer
  logic                  res_valid;
  logic                  res_neg;
  logic [NumDigits*BCD_BITS-1:0] res_bcd;
  logic                  res_take;

  // sign and magnitude split
  sdau_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .value   (value),
    .wr_en   (f_wr_en),
    .wr_data (f_wr_data),
    .q_full  (q_full)
  );

  // decouples the front from the converter
  sdau_queue #(.WIDTH(VALUE_BITS + 1)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (f_wr_en),
    .wr_data (f_wr_data),
    .q_full  (q_full),
    .rd_en   (q_rd_en),
    .q_valid (q_valid),
    .rd_data (q_rd_data)
  );

  // magnitude to bcd digits
  sdau_conv #(.VALUE_BITS(VALUE_BITS)) u_conv (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .rd_data   (q_rd_data),
    .rd_en     (q_rd_en),
    .res_valid (res_valid),
    .res_neg   (res_neg),
    .res_bcd   (res_bcd),
    .res_take  (res_take)
  );

  // sign and digits out, most significant first
  sdau_emit #(.VALUE_BITS(VALUE_BITS)) u_emit (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_neg   (res_neg),
    .res_bcd   (res_bcd),
    .res_take  (res_take),
    .char_code (char_code),
    .last_char (last_char),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

@@ rtl/core/sdau_checker.sv @@
// ----------------------------------------------------------------------------
// sdau_checker
// port-level checks for the signed integer to decimal ascii unit
// ----------------------------------------------------------------------------
module sdau_checker
  import sdau_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 push,
  input logic                 full,
  input logic [CHAR_BITS-1:0] char_code,
  input logic                 last_char,
  input logic                 empty,
  input logic                 pop
);

  // nothing waits on the output right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("output not empty after reset");

  // a stalled character holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(char_code) && $stable(last_char)))
    else $error("waiting character changed");

  // only minus or a digit ever leaves
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((char_code == CHAR_MINUS) ||
                ((char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE))))
    else $error("character outside minus and digits");

  // a minus sign never ends a number
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && (char_code == CHAR_MINUS)) |-> !last_char)
    else $error("minus marked as last character");

  // full never rises without an accepted push beat
  a_full_cause: assert property (@(posedge clk) disable iff (rst)
    (!full && !(push && !full)) |=> !full)
    else $error("full rose without an accepted item");

endmodule

bind signed_int_to_decimal_ascii_unit sdau_checker u_sdau_checker (
  .clk       (clk),
  .rst       (rst),
  .push      (push),
  .full      (full),
  .char_code (char_code),
  .last_char (last_char),
  .empty     (empty),
  .pop       (pop)
);
